FILE: rtl/bffla_pkg.sv
// Shared constants, status codes and header checks for the best-fit allocator.
package bffla_pkg;

  localparam int POOL_BYTES_DEF = 65536;
  localparam int POOL_W = 17;
  localparam int STEP_W = 13;

  localparam logic [31:0] TAG_FREE = 32'hDEADBEEF;
  localparam logic [31:0] TAG_USED = 32'hBEEFDEAD;

  localparam logic [1:0] F_MAGIC = 2'd0;
  localparam logic [1:0] F_SIZE  = 2'd1;
  localparam logic [1:0] F_NEXT  = 2'd2;
  localparam logic [1:0] F_PREV  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;

  // Aligned offset with a full 16-byte header inside the pool.
  function automatic logic link_ok(logic [31:0] x, logic [POOL_W-1:0] pool);
    return (x[1:0] == 2'b00) && ((33'(x) + 33'd16) <= 33'(pool));
  endfunction

  // Plausible block size for a header at off.
  function automatic logic size_ok(logic [31:0] s, logic [15:0] off,
                                   logic [POOL_W-1:0] pool);
    return (s[1:0] == 2'b00) && (s >= 32'd16) && ((33'(s) + 33'(off)) <= 33'(pool));
  endfunction

endpackage

FILE: rtl/bffla_ram.sv
// Generic single-port RAM with registered read.
module bffla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/best_fit_free_list_allocator.sv
// Best-fit free-list allocator: sequencer over one header-word RAM.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------
//  in      | in_valid / in_stall | action, request_bytes, block_offset
//  out     | out_valid/out_stall | status, result_offset
//  cfg     | cfg_wr_en           | cfg_wr_data (pool_size_log2)
//
// One item at a time. An allocate walks every free block through the single
//   RAM port, then chooses the best fit and issues up to 8 header writes;
//   a free checks its header, walks up to its insertion point, then relinks
//   and coalesces. All of this is serialised on the single RAM port.
// Reset and each configuration write clear the whole RAM, one word a cycle,
//   then write the first header; in_stall stays high meanwhile.
// out_stall holds the result item; no new item is taken until it leaves.
module best_fit_free_list_allocator #(
  parameter int POOL_BYTES = bffla_pkg::POOL_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] request_bytes,
  input  logic [15:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] result_offset,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  import bffla_pkg::*;

  localparam int MEM_WORDS = POOL_BYTES / 4;
  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [21:0] {
    S_INIT  = 22'd1 << 0,
    S_IDLE  = 22'd1 << 1,
    S_FM    = 22'd1 << 2,
    S_FS    = 22'd1 << 3,
    S_W0    = 22'd1 << 4,
    S_W1    = 22'd1 << 5,
    S_W2    = 22'd1 << 6,
    S_W3    = 22'd1 << 7,
    S_W4    = 22'd1 << 8,
    S_AFIN  = 22'd1 << 9,
    S_FLINK = 22'd1 << 10,
    S_FAB   = 22'd1 << 11,
    S_P0    = 22'd1 << 12,
    S_P1    = 22'd1 << 13,
    S_P2    = 22'd1 << 14,
    S_AB0   = 22'd1 << 15,
    S_AB1   = 22'd1 << 16,
    S_AB2   = 22'd1 << 17,
    S_AB3   = 22'd1 << 18,
    S_WR    = 22'd1 << 19,
    S_OUT   = 22'd1 << 20,
    S_CLR   = 22'd1 << 21
  } state_t;

  // Word address of header field f of the block at byte offset off.
  function automatic logic [AW-1:0] wa(logic [15:0] off, logic [1:0] f);
    return AW'(32'(off[15:2]) + 32'(f));
  endfunction

  // Pool bytes for a log2 setting: clamp to 10..16, never above the RAM.
  function automatic logic [POOL_W-1:0] pool_of(logic [4:0] l5);
    logic [4:0]  l;
    logic [31:0] p;
    l = (l5 < 5'd10) ? 5'd10 : ((l5 > 5'd16) ? 5'd16 : l5);
    p = 32'd1 << l;
    if (p > (32'(POOL_BYTES) & ~32'd3)) begin
      p = 32'(POOL_BYTES) & ~32'd3;
    end
    return POOL_W'(p);
  endfunction

  state_t state, wr_ret, ab_ret;

  logic [POOL_W-1:0] pool;
  logic [15:0]       head;
  logic              is_free;
  logic [16:0]       bytes;
  logic [15:0]       cur, hoff, nxt, prv, lo, hi, best, best_nx, best_pv, head_pv;
  logic [31:0]       cs, cnx, hs, bsize, lsz, hsz;
  logic              found, prv_lt;
  logic [STEP_W-1:0] steps;
  logic [1:0]        st;
  logic [15:0]       res;
  logic [AW-1:0]     clr_addr;

  logic [AW-1:0] wq_addr [0:7];
  logic [31:0]   wq_data [0:7];
  logic [2:0]    wq_idx, wq_last;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, q;

  logic [15:0] h_in, nf;

  assign h_in = block_offset - 16'd8;
  assign nf   = best + bytes[15:0];

  bffla_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (q)
  );

  // Single RAM port: clear after reset or a configuration write, drain the
  // write queue, otherwise issue the read for the word the next state expects.
  always_comb begin
    mem_we    = (state == S_WR) || (state == S_CLR);
    mem_wdata = (state == S_CLR) ? 32'd0 : wq_data[wq_idx];
    case (state)
      S_CLR:   mem_addr = clr_addr;
      S_WR:    mem_addr = wq_addr[wq_idx];
      S_IDLE:  mem_addr = wa(h_in, F_MAGIC);
      S_FM:    mem_addr = wa(hoff, F_SIZE);
      S_W0:    mem_addr = wa(cur, F_MAGIC);
      S_W1:    mem_addr = wa(cur, F_SIZE);
      S_W2:    mem_addr = wa(cur, F_NEXT);
      S_W3:    mem_addr = wa(cur, F_PREV);
      S_P0:    mem_addr = wa(hoff, F_PREV);
      S_P1:    mem_addr = wa(q[15:0], F_SIZE);
      S_AB0:   mem_addr = wa(lo, F_SIZE);
      S_AB1:   mem_addr = wa(hi, F_SIZE);
      S_AB2:   mem_addr = wa(hi, F_NEXT);
      default: mem_addr = '0;
    endcase
  end

  assign in_stall      = (state != S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign status        = st;
  assign result_offset = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      wr_ret <= S_IDLE;
      ab_ret <= S_OUT;
      pool   <= pool_of(5'd16);
      head   <= '0;
      wq_idx <= '0;
      st     <= ST_OK;
      res    <= '0;
    end else if (cfg_wr_en) begin
      // Reinitialise the pool on any setting write.
      pool  <= pool_of(cfg_wr_data);
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT: begin
          clr_addr <= '0;
          state    <= S_CLR;
        end
        S_CLR: begin
          // Wipe every word, then lay down one free block over the pool.
          if (clr_addr == AW'(MEM_WORDS - 1)) begin
            wq_addr[0] <= wa(16'd0, F_MAGIC); wq_data[0] <= TAG_FREE;
            wq_addr[1] <= wa(16'd0, F_SIZE);  wq_data[1] <= 32'(pool);
            wq_addr[2] <= wa(16'd0, F_NEXT);  wq_data[2] <= '0;
            wq_addr[3] <= wa(16'd0, F_PREV);  wq_data[3] <= '0;
            wq_last <= 3'd3;
            wq_idx  <= '0;
            head    <= '0;
            wr_ret  <= S_IDLE;
            state   <= S_WR;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            st      <= ST_OK;
            res     <= '0;
            is_free <= (action != ACT_ALLOC);
            cur     <= head;
            steps   <= '0;
            found   <= 1'b0;
            bsize   <= '0;
            hoff    <= h_in;
            if (action == ACT_ALLOC) begin
              // Pad by the header, round to words, at least 16 bytes.
              if (((17'(request_bytes) + 17'd11) & ~17'd3) < 17'd16) begin
                bytes <= 17'd16;
              end else begin
                bytes <= (17'(request_bytes) + 17'd11) & ~17'd3;
              end
              state <= S_W0;
            end else if (block_offset < 16'd8 || !link_ok(32'(h_in), pool)) begin
              st    <= ST_BADFREE;
              state <= S_OUT;
            end else begin
              state <= S_FM;
            end
          end
        end
        S_FM: begin
          if (q != TAG_USED) begin
            st    <= ST_BADFREE;
            state <= S_OUT;
          end else begin
            state <= S_FS;
          end
        end
        S_FS: begin
          hs <= q;
          if (!size_ok(q, hoff, pool)) begin
            st    <= ST_CORRUPT;
            state <= S_OUT;
          end else begin
            state <= S_W0;
          end
        end
        S_W0: begin
          if (!link_ok(32'(cur), pool) || (32'(steps) > 32'(pool >> 4))) begin
            st    <= ST_CORRUPT;
            state <= S_OUT;
          end else begin
            state <= S_W1;
          end
        end
        S_W1: begin
          if (q != TAG_FREE) begin
            st    <= ST_CORRUPT;
            state <= S_OUT;
          end else begin
            state <= S_W2;
          end
        end
        S_W2: begin
          cs <= q;
          if (!size_ok(q, cur, pool)) begin
            st    <= ST_CORRUPT;
            state <= S_OUT;
          end else begin
            state <= S_W3;
          end
        end
        S_W3: begin
          cnx <= q;
          if (!link_ok(q, pool)) begin
            st    <= ST_CORRUPT;
            state <= S_OUT;
          end else begin
            state <= S_W4;
          end
        end
        S_W4: begin
          if (!link_ok(q, pool)) begin
            st    <= ST_CORRUPT;
            state <= S_OUT;
          end else if (!is_free) begin
            // Keep the smallest fit; first met wins a tie.
            if (cs >= 32'(bytes) && (!found || cs < bsize)) begin
              best    <= cur;
              bsize   <= cs;
              found   <= 1'b1;
              best_nx <= cnx[15:0];
              best_pv <= q[15:0];
            end
            cur   <= cnx[15:0];
            steps <= steps + 1'b1;
            state <= (cnx == 32'(head)) ? S_AFIN : S_W0;
          end else begin
            if (steps == '0) begin
              head_pv <= q[15:0];
            end
            if (cur > hoff) begin
              nxt   <= cur;
              prv   <= q[15:0];
              state <= S_FLINK;
            end else if (cnx == 32'(head)) begin
              // Wrapped round: insert before the head.
              nxt   <= head;
              prv   <= (steps == '0) ? q[15:0] : head_pv;
              state <= S_FLINK;
            end else begin
              cur   <= cnx[15:0];
              steps <= steps + 1'b1;
              state <= S_W0;
            end
          end
        end
        S_AFIN: begin
          wq_idx <= '0;
          wr_ret <= S_OUT;
          if (!found) begin
            st    <= ST_NOFIT;
            state <= S_OUT;
          end else if (bsize < (32'(bytes) + 32'd32)) begin
            if (best_nx == best) begin
              // Never hand out the last free block.
              st    <= ST_NOFIT;
              state <= S_OUT;
            end else begin
              wq_addr[0] <= wa(best, F_MAGIC);    wq_data[0] <= TAG_USED;
              wq_addr[1] <= wa(best_pv, F_NEXT);  wq_data[1] <= 32'(best_nx);
              wq_addr[2] <= wa(best_nx, F_PREV);  wq_data[2] <= 32'(best_pv);
              wq_last <= 3'd2;
              if (best == head) begin
                head <= best_nx;
              end
              res   <= best + 16'd8;
              state <= S_WR;
            end
          end else begin
            // Split: the tail stays free and takes the block's list place.
            wq_addr[0] <= wa(nf, F_MAGIC); wq_data[0] <= TAG_FREE;
            wq_addr[1] <= wa(nf, F_SIZE);  wq_data[1] <= bsize - 32'(bytes);
            wq_addr[2] <= wa(nf, F_NEXT);
            wq_data[2] <= (best_nx == best) ? 32'(nf) : 32'(best_nx);
            wq_addr[3] <= wa(nf, F_PREV);
            wq_data[3] <= (best_nx == best) ? 32'(nf) : 32'(best_pv);
            wq_addr[4] <= wa(best, F_MAGIC);    wq_data[4] <= TAG_USED;
            wq_addr[5] <= wa(best, F_SIZE);     wq_data[5] <= 32'(bytes);
            wq_addr[6] <= wa(best_nx, F_PREV);  wq_data[6] <= 32'(nf);
            wq_addr[7] <= wa(best_pv, F_NEXT);  wq_data[7] <= 32'(nf);
            wq_last <= (best_nx == best) ? 3'd5 : 3'd7;
            if (best == head) begin
              head <= nf;
            end
            res   <= best + 16'd8;
            state <= S_WR;
          end
        end
        S_FLINK: begin
          wq_addr[0] <= wa(hoff, F_MAGIC); wq_data[0] <= TAG_FREE;
          wq_addr[1] <= wa(hoff, F_NEXT);  wq_data[1] <= 32'(nxt);
          wq_addr[2] <= wa(hoff, F_PREV);  wq_data[2] <= 32'(prv);
          wq_addr[3] <= wa(prv, F_NEXT);   wq_data[3] <= 32'(hoff);
          wq_addr[4] <= wa(nxt, F_PREV);   wq_data[4] <= 32'(hoff);
          wq_last <= 3'd4;
          wq_idx  <= '0;
          if (hoff < head) begin
            head <= hoff;
          end
          wr_ret <= S_FAB;
          state  <= S_WR;
        end
        S_FAB: begin
          // Merge with the block above when they touch.
          if (nxt > hoff && (32'(hoff) + hs) == 32'(nxt)) begin
            lo     <= hoff;
            hi     <= nxt;
            ab_ret <= S_P0;
            state  <= S_AB0;
          end else begin
            state <= S_P0;
          end
        end
        S_P0: begin
          state <= S_P1;
        end
        S_P1: begin
          prv    <= q[15:0];
          prv_lt <= (q < 32'(hoff));
          state  <= S_P2;
        end
        S_P2: begin
          // Merge into the block below when they touch.
          if (prv_lt && (32'(prv) + q) == 32'(hoff)) begin
            lo     <= prv;
            hi     <= hoff;
            ab_ret <= S_OUT;
            state  <= S_AB0;
          end else begin
            state <= S_OUT;
          end
        end
        S_AB0: begin
          state <= S_AB1;
        end
        S_AB1: begin
          lsz   <= q;
          state <= S_AB2;
        end
        S_AB2: begin
          hsz   <= q;
          state <= S_AB3;
        end
        S_AB3: begin
          wq_addr[0] <= wa(lo, F_SIZE);      wq_data[0] <= lsz + hsz;
          wq_addr[1] <= wa(hi, F_MAGIC);     wq_data[1] <= '0;
          wq_addr[2] <= wa(lo, F_NEXT);      wq_data[2] <= q;
          wq_addr[3] <= wa(q[15:0], F_PREV); wq_data[3] <= 32'(lo);
          wq_last <= 3'd3;
          wq_idx  <= '0;
          wr_ret  <= ab_ret;
          state   <= S_WR;
        end
        S_WR: begin
          if (wq_idx == wq_last) begin
            wq_idx <= '0;
            state  <= wr_ret;
          end else begin
            wq_idx <= wq_idx + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

FILE: rtl/bffla_chk.sv
// Port-level checker for the best-fit allocator, bound to the top level.
module bffla_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] result_offset
);

  import bffla_pkg::*;

  // An item is only taken while no result is pending.
  a_idle_excl: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("item taken while a result is pending");

  // One item at a time: stall rises right after acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  // Failures carry no offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_offset == 16'd0)
    else $error("failed item carries an offset");

  // Payload offsets are word aligned.
  a_align: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> result_offset[1:0] == 2'b00)
    else $error("unaligned result offset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_offset))
    else $error("stalled result changed");

endmodule

bind best_fit_free_list_allocator bffla_chk u_bffla_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .result_offset (result_offset)
);
